// File: sv/sedu_pkg.sv
package sedu_pkg;

    localparam int BYTE_W = 8;

    // datapath operation selected by the controller state
    typedef enum logic [2:0] {
        OP_LOAD,
        OP_HANDLE,
        OP_RESOLVE,
        OP_FLUSH,
        OP_END
    } t_op;

    typedef struct packed {
        logic in_drop;     // offered byte is a quote that opens or closes the string
        logic in_flush;    // offered byte ends the string while an escape is open
        logic stall;       // operation cannot complete this cycle
        logic to_resolve;  // byte in work completes four bytes after \u
        logic more;        // replayed bytes remain after the one in work
        logic flush_next;  // string ends with an escape left open
        logic seq_last;    // sequence index at its final byte
        logic hex_ok;      // all four collected bytes are hex digits
    } t_stat;

endpackage

// File: sv/sedu_ctrl.sv
module sedu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  sedu_pkg::t_stat i_stat,
    output logic            o_ready,
    output sedu_pkg::t_op   o_op
);
    import sedu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HANDLE,
        S_RESOLVE,
        S_FLUSH,
        S_END
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_stat.in_drop) begin
                        n_state = i_stat.in_flush ? S_FLUSH : S_END;
                    end else begin
                        n_state = S_HANDLE;
                    end
                end
            end
            S_HANDLE: begin
                if (!i_stat.stall) begin
                    priority if (i_stat.to_resolve) n_state = S_RESOLVE;
                    else if (i_stat.more)           n_state = S_HANDLE;
                    else if (i_stat.flush_next)     n_state = S_FLUSH;
                    else                            n_state = S_END;
                end
            end
            S_RESOLVE: begin
                // broken hex goes back to replay the leftover bytes
                if (!i_stat.stall && i_stat.seq_last) begin
                    n_state = i_stat.hex_ok ? S_END : S_HANDLE;
                end
            end
            S_FLUSH: begin
                if (!i_stat.stall && i_stat.seq_last) n_state = S_END;
            end
            S_END: begin
                if (!i_stat.stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:    o_op = OP_LOAD;
            S_HANDLE:  o_op = OP_HANDLE;
            S_RESOLVE: o_op = OP_RESOLVE;
            S_FLUSH:   o_op = OP_FLUSH;
            S_END:     o_op = OP_END;
            default:   o_op = OP_END;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

// File: sv/sedu_dp.sv
module sedu_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sedu_pkg::t_op                 i_op,
    input  logic                          i_valid,
    input  logic [sedu_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic                          i_first,
    input  logic                          i_last,
    input  logic                          i_ready,
    output sedu_pkg::t_stat               o_stat,
    output logic                          o_valid,
    output logic [sedu_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                          o_has_byte,
    output logic                          o_run_end,
    output logic                          o_string_end
);
    import sedu_pkg::*;

    typedef enum logic [1:0] {
        M_NORMAL = 2'd0,
        M_ESCAPE = 2'd1,
        M_HEX    = 2'd2
    } t_mode;

    localparam logic [7:0]  CH_BSL   = 8'h5C;
    localparam logic [7:0]  CH_QUOTE = 8'h22;
    localparam logic [7:0]  CH_U     = 8'h75;
    localparam logic [7:0]  CH_0     = 8'h30;
    localparam logic [7:0]  CH_9     = 8'h39;
    localparam logic [7:0]  CH_LA    = 8'h61;
    localparam logic [7:0]  CH_LF    = 8'h66;
    localparam logic [7:0]  CH_UA    = 8'h41;
    localparam logic [7:0]  CH_UF    = 8'h46;
    localparam logic [7:0]  CH_A     = 8'h61;
    localparam logic [7:0]  CH_B     = 8'h62;
    localparam logic [7:0]  CH_T     = 8'h74;
    localparam logic [7:0]  CH_N     = 8'h6E;
    localparam logic [7:0]  CH_V     = 8'h76;
    localparam logic [7:0]  CH_F     = 8'h66;
    localparam logic [7:0]  CH_R     = 8'h72;
    localparam logic [15:0] CP_LIM1  = 16'h0080;
    localparam logic [15:0] CP_LIM2  = 16'h0800;
    localparam logic [7:0]  LEAD2    = 8'hC0;
    localparam logic [7:0]  LEAD3    = 8'hE0;
    localparam logic [7:0]  CONT     = 8'h80;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= CH_0 && c <= CH_9) begin
            r = {1'b1, 4'(c - CH_0)};
        end else if (c >= CH_LA && c <= CH_LF) begin
            r = {1'b1, 4'(c - CH_LA + 8'd10)};
        end else if (c >= CH_UA && c <= CH_UF) begin
            r = {1'b1, 4'(c - CH_UA + 8'd10)};
        end
        return r;
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            CH_0:    r = 8'h00;
            CH_A:    r = 8'h07;
            CH_B:    r = 8'h08;
            CH_T:    r = 8'h09;
            CH_N:    r = 8'h0A;
            CH_V:    r = 8'h0B;
            CH_F:    r = 8'h0C;
            CH_R:    r = 8'h0D;
            default: r = c;
        endcase
        return r;
    endfunction

    // state
    t_mode       r_mode;
    logic [2:0]  r_count;
    logic [7:0]  r_buf [4];
    logic        r_replay;
    logic [1:0]  r_rp;
    logic [2:0]  r_idx;
    logic [7:0]  r_cur;
    logic        r_last;
    logic [7:0]  r_pbyte;
    logic        r_pend_v;
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic        r_ohas;
    logic        r_orun;
    logic        r_osend;

    logic [1:0]  rd_addr;
    logic [7:0]  rd_byte;
    logic [7:0]  cur_c;
    logic [4:0]  dig [4];
    logic [2:0]  hex_k;
    logic        hex_ok;
    logic [15:0] cp;
    logic [2:0]  utf_len;
    logic [7:0]  utf_byte;
    logic [7:0]  raw_byte;
    logic [2:0]  seq_len;
    logic [7:0]  seq_byte;
    logic        seq_last;
    logic        h_emit;
    logic [7:0]  h_byte;
    t_mode       h_mode_n;
    logic        em_req;
    logic [7:0]  em_byte;
    logic        out_free;
    logic        end_need;
    logic        stall;
    logic        push_emit;
    logic        push_end;

    // one buffer read port, shared between replay and raw output
    assign rd_addr = (i_op == OP_HANDLE) ? r_rp : 2'(r_idx - 3'd2);
    assign rd_byte = r_buf[rd_addr];
    assign cur_c   = r_replay ? rd_byte : r_cur;

    always_comb begin
        for (int g = 0; g < 4; g++) begin
            dig[g] = hex_digit(r_buf[g]);
        end
    end

    always_comb begin
        if (!dig[0][4])      hex_k = 3'd0;
        else if (!dig[1][4]) hex_k = 3'd1;
        else if (!dig[2][4]) hex_k = 3'd2;
        else if (!dig[3][4]) hex_k = 3'd3;
        else                 hex_k = 3'd4;
    end

    assign hex_ok = (hex_k == 3'd4);
    assign cp     = {dig[0][3:0], dig[1][3:0], dig[2][3:0], dig[3][3:0]};

    always_comb begin
        if (cp < CP_LIM1)      utf_len = 3'd1;
        else if (cp < CP_LIM2) utf_len = 3'd2;
        else                   utf_len = 3'd3;
    end

    always_comb begin
        utf_byte = cp[7:0];
        if (utf_len == 3'd2) begin
            utf_byte = (r_idx == 3'd0) ? (LEAD2 | {3'b000, cp[10:6]})
                                       : (CONT | {2'b00, cp[5:0]});
        end else if (utf_len == 3'd3) begin
            if (r_idx == 3'd0)      utf_byte = LEAD3 | {4'b0000, cp[15:12]};
            else if (r_idx == 3'd1) utf_byte = CONT | {2'b00, cp[11:6]};
            else                    utf_byte = CONT | {2'b00, cp[5:0]};
        end
    end

    always_comb begin
        if (r_idx == 3'd0)      raw_byte = CH_BSL;
        else if (r_idx == 3'd1) raw_byte = CH_U;
        else                    raw_byte = rd_byte;
    end

    always_comb begin
        if (i_op == OP_RESOLVE) begin
            seq_len  = hex_ok ? utf_len : 3'd2 + hex_k;
            seq_byte = hex_ok ? utf_byte : raw_byte;
        end else begin
            seq_len  = (r_mode == M_ESCAPE) ? 3'd1 : 3'd2 + r_count;
            seq_byte = raw_byte;
        end
    end

    assign seq_last = (r_idx == seq_len - 3'd1);

    always_comb begin
        h_emit   = 1'b0;
        h_byte   = cur_c;
        h_mode_n = M_NORMAL;
        unique case (r_mode)
            M_ESCAPE: begin
                if (cur_c == CH_U) begin
                    h_mode_n = M_HEX;
                end else begin
                    h_emit = 1'b1;
                    h_byte = esc_map(cur_c);
                end
            end
            M_HEX: h_mode_n = M_HEX;
            default: begin
                if (cur_c == CH_BSL) h_mode_n = M_ESCAPE;
                else                 h_emit   = 1'b1;
            end
        endcase
    end

    always_comb begin
        em_req  = 1'b0;
        em_byte = seq_byte;
        unique case (i_op)
            OP_HANDLE: begin
                em_req  = h_emit;
                em_byte = h_byte;
            end
            OP_RESOLVE, OP_FLUSH: em_req = 1'b1;
            default: em_req = 1'b0;
        endcase
    end

    // the newest byte waits in the pending register until it is known
    // whether it is the last result of the transaction
    assign out_free  = !r_ovalid || i_ready;
    assign end_need  = r_pend_v || r_last;
    assign stall     = (em_req && r_pend_v && !out_free)
                     || ((i_op == OP_END) && end_need && !out_free);
    assign push_emit = em_req && r_pend_v && !stall;
    assign push_end  = (i_op == OP_END) && end_need && !stall;

    always_ff @(posedge i_clk) begin
        if ((i_op == OP_LOAD) && i_valid) begin
            r_cur  <= i_in_byte;
            r_last <= i_last;
        end
        if ((i_op == OP_HANDLE) && (r_mode == M_HEX)) begin
            r_buf[r_count[1:0]] <= cur_c;
        end
        if (em_req && !stall) begin
            r_pbyte <= em_byte;
        end
        if (push_emit) begin
            r_obyte <= r_pbyte;
            r_ohas  <= 1'b1;
            r_orun  <= 1'b0;
            r_osend <= 1'b0;
        end else if (push_end) begin
            r_obyte <= r_pend_v ? r_pbyte : 8'h00;
            r_ohas  <= r_pend_v;
            r_orun  <= 1'b1;
            r_osend <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_NORMAL;
            r_count  <= '0;
            r_replay <= 1'b0;
            r_rp     <= '0;
            r_idx    <= '0;
            r_pend_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (push_emit || push_end) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (i_op)
                OP_LOAD: begin
                    if (i_valid) begin
                        r_replay <= 1'b0;
                        r_idx    <= '0;
                        if (i_first) begin
                            r_mode  <= M_NORMAL;
                            r_count <= '0;
                        end
                    end
                end
                OP_HANDLE: begin
                    if (!stall) begin
                        r_mode <= h_mode_n;
                        r_idx  <= '0;
                        if ((r_mode == M_ESCAPE) && (cur_c == CH_U)) r_count <= '0;
                        if (r_mode == M_HEX) r_count <= r_count + 3'd1;
                        if (r_replay) begin
                            r_rp <= r_rp + 2'd1;
                            if (r_rp == 2'd3) r_replay <= 1'b0;
                        end
                        if (h_emit) r_pend_v <= 1'b1;
                    end
                end
                OP_RESOLVE, OP_FLUSH: begin
                    if (!stall) begin
                        r_pend_v <= 1'b1;
                        r_idx    <= seq_last ? 3'd0 : r_idx + 3'd1;
                        if (seq_last) begin
                            r_mode  <= M_NORMAL;
                            r_count <= '0;
                            // replay the bytes from the first non-hex one
                            if ((i_op == OP_RESOLVE) && !hex_ok) begin
                                r_replay <= 1'b1;
                                r_rp     <= hex_k[1:0];
                            end
                        end
                    end
                end
                OP_END: begin
                    if (!stall) r_pend_v <= 1'b0;
                end
                default: r_pend_v <= r_pend_v;
            endcase
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.in_drop    = (i_in_byte == CH_QUOTE) && (i_first || i_last);
        o_stat.in_flush   = i_last && !i_first && (r_mode != M_NORMAL);
        o_stat.stall      = stall;
        o_stat.to_resolve = (r_mode == M_HEX) && (r_count == 3'd3);
        o_stat.more       = r_replay && (r_rp != 2'd3);
        o_stat.flush_next = r_last && (h_mode_n != M_NORMAL);
        o_stat.seq_last   = seq_last;
        o_stat.hex_ok     = hex_ok;
    end

    assign o_valid      = r_ovalid;
    assign o_out_byte   = r_obyte;
    assign o_has_byte   = r_ohas;
    assign o_run_end    = r_orun;
    assign o_string_end = r_osend;

endmodule

// File: sv/string_escape_decoder_utf8.sv
// String literal unescaper with UTF-8 output.
// Input channel (i_valid / o_ready): one byte of a quoted literal per
// transaction, with i_first and i_last marking the ends of the string.
// Output channel (o_valid / i_ready): one decoded byte per transaction;
// o_run_end marks the last byte caused by an input transaction and
// o_string_end the final byte of the string. A string that ends with no
// data gives one transaction with o_has_byte low.
// Timing: one input transaction at a time, one emitted byte per cycle
// while the receiver is ready. A byte decoded in place passes load,
// decode and release, a dropped quote load and release. The byte that
// completes a \u sequence adds a resolve step for its 1 to 3 UTF-8
// bytes, or for broken hex the 2 to 5 bytes of the raw \u prefix and
// valid digits and a replay of the remaining 1 to 4 bytes. A string that
// ends inside an escape adds a flush of its 1 to 5 raw bytes. The
// newest byte waits in a pending register until its end marks are known.
// Reset clears the escape state and empties the output register.
// When the receiver stalls, the block holds the step it is in; the next
// input is taken only once the last result of the current one has moved
// into the output register.
module string_escape_decoder_utf8 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [sedu_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic                          i_first,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [sedu_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                          o_has_byte,
    output logic                          o_run_end,
    output logic                          o_string_end
);
    import sedu_pkg::*;

    t_op   op;
    t_stat stat;

    sedu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_ready (o_ready),
        .o_op    (op)
    );

    sedu_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_valid      (i_valid),
        .i_in_byte    (i_in_byte),
        .i_first      (i_first),
        .i_last       (i_last),
        .i_ready      (i_ready),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_out_byte   (o_out_byte),
        .o_has_byte   (o_has_byte),
        .o_run_end    (o_run_end),
        .o_string_end (o_string_end)
    );

    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_byte) |-> (o_run_end && o_string_end && (o_out_byte == 8'h00)))
        else $error("empty marker without end marks");

    a_string_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_string_end) |-> o_run_end)
        else $error("string end without run end");

    a_single_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second transaction taken while busy");

    a_load_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == OP_LOAD) |-> (!stat.stall && o_ready))
        else $error("stall or busy while loading");

endmodule
